### src/frlh_pkg.sv
// ----------------------------------------------------------------------------
// frlh_pkg
// Shared constants, codes, types and helpers of the read length histogram.
// ----------------------------------------------------------------------------
package frlh_pkg;

    // Default number of histogram bins and width of every counter.
    localparam int MAX_LEN    = 1024;
    localparam int COUNT_BITS = 32;

    // Percent scale: 100 percent with 8 fraction bits.
    localparam int PCT_SCALE = 25600;
    localparam int PCT_W     = 15;

    // Characters of the text stream.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;

    // Request actions.
    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_EOF   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_BAD_SEP = 2'd2;
    localparam logic [1:0] ST_SKIPPED = 2'd3;

    // Record phases.
    localparam logic [1:0] PH_HEADER    = 2'd0;
    localparam logic [1:0] PH_SEQUENCE  = 2'd1;
    localparam logic [1:0] PH_SEPARATOR = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_RD,
        S_UPD_WR,
        S_SCAN,
        S_DRAIN,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic upd_rd;
        logic upd_wr;
        logic scan_issue;
        logic mul;
        logic div_step;
        logic load_out;
        logic load_now;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_upd;
        logic is_query;
        logic addr_last;
        logic div_last;
        logic sel_last;
        logic out_free;
    } t_stat;

    // Saturating add of two counters.
    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

### src/frlh_ram.sv
// ----------------------------------------------------------------------------
// frlh_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module frlh_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 1024,
    localparam int ADDR_W = $clog2(P_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [P_WIDTH-1:0] i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/frlh_ctrl.sv
// ----------------------------------------------------------------------------
// frlh_ctrl
// Controller: sequences clearing, bin updates, query scans and divisions.
// ----------------------------------------------------------------------------
module frlh_ctrl
    import frlh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   w_take;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_take     = o_in_ready && i_in_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_stat.addr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (w_take) begin
                    if (i_stat.need_upd) begin
                        n_state = S_UPD_RD;
                    end else if (i_stat.is_query) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_UPD_RD: n_state = S_UPD_WR;
            S_UPD_WR: n_state = S_OUT;
            S_SCAN:   if (i_stat.addr_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_MUL;
            S_MUL:    n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = i_stat.sel_last ? S_OUT : S_MUL;
                end
            end
            S_OUT:    if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR:  o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_cmd.accept   = w_take;
                o_cmd.load_now = w_take && !i_stat.need_upd && !i_stat.is_query;
            end
            S_UPD_RD: o_cmd.upd_rd = 1'b1;
            S_UPD_WR: o_cmd.upd_wr = 1'b1;
            S_SCAN:   o_cmd.scan_issue = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_OUT:    o_cmd.load_out = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

### src/frlh_dp.sv
// ----------------------------------------------------------------------------
// frlh_dp
// Datapath: line parser, histogram memory, scan sums, divider, result register.
// ----------------------------------------------------------------------------
module frlh_dp
    import frlh_pkg::*;
#(
    parameter int P_MAX_LEN = MAX_LEN,
    localparam int LEN_W  = $clog2(P_MAX_LEN + 1),
    localparam int ADDR_W = $clog2(P_MAX_LEN)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_data_byte,
    input  logic [LEN_W-1:0] i_query_length,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [LEN_W-1:0] o_row_length,
    output t_count           o_count_equal,
    output t_count           o_count_at_most,
    output t_count           o_count_at_least,
    output logic [PCT_W-1:0] o_percent_equal,
    output logic [PCT_W-1:0] o_percent_at_most,
    output logic [PCT_W-1:0] o_percent_at_least,
    output t_count           o_total_reads,
    output logic [LEN_W-1:0] o_longest_length
);

    localparam int PROD_W = COUNT_BITS + PCT_W;
    localparam int K_W    = $clog2(PCT_W);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(P_MAX_LEN);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(P_MAX_LEN - 1);

    // Parser and statistics state.
    logic [1:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_lb, n_lb;
    logic             r_skip, n_skip;
    t_count           r_total;
    logic [LEN_W-1:0] r_longest;

    // Pending request.
    logic [LEN_W-1:0] r_upd_len;
    logic [LEN_W-1:0] r_qlen, w_qlen;
    logic             r_is_q;
    logic [1:0]       r_status_p, w_status;
    logic             w_need_upd;

    // Scan, divider and result storage.
    logic [ADDR_W-1:0] r_addr, r_pidx;
    logic              r_pend;
    t_count            r_ceq, r_cle, r_cge;
    logic [1:0]        r_sel;
    logic [PROD_W-1:0] r_rem, w_dsh;
    logic [PCT_W-1:0]  r_quo, w_quo_n;
    logic [K_W-1:0]    r_k;
    logic [PCT_W-1:0]  r_peq, r_ple, r_pge;
    t_count            w_cnt;
    logic [LEN_W-1:0]  w_plen;

    // Memory ports.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr, w_uaddr;
    t_count            w_wdata, w_rdata;

    // Output register.
    logic             r_ov;
    logic [1:0]       r_o_status;
    logic [LEN_W-1:0] r_o_row;
    t_count           r_o_ceq, r_o_cle, r_o_cge, r_o_total;
    logic [PCT_W-1:0] r_o_peq, r_o_ple, r_o_pge;
    logic [LEN_W-1:0] r_o_longest;

    // Line parser for the request at the input.
    always_comb begin
        n_phase    = r_phase;
        n_lb       = r_lb;
        n_skip     = r_skip;
        w_status   = ST_OK;
        w_need_upd = 1'b0;
        case (i_action)
            ACT_DATA: begin
                if (r_skip) begin
                    w_status = ST_SKIPPED;
                end else if (i_data_byte == CH_NEWLINE) begin
                    if (r_lb != '0) begin
                        w_need_upd = (r_phase == PH_SEQUENCE);
                        n_phase    = r_phase + 2'd1;
                        n_lb       = '0;
                    end
                end else if (r_lb == '0 && r_phase == PH_HEADER && i_data_byte != CH_AT) begin
                    w_status = ST_BAD_HDR;
                    n_skip   = 1'b1;
                end else if (r_lb == '0 && r_phase == PH_SEPARATOR
                             && i_data_byte != CH_PLUS) begin
                    w_status = ST_BAD_SEP;
                    n_skip   = 1'b1;
                end else if (r_lb < LEN_MAX) begin
                    n_lb = r_lb + 1'b1;
                end
            end
            ACT_EOF: begin
                w_need_upd = !r_skip && (r_lb != '0) && (r_phase == PH_SEQUENCE);
                n_phase    = PH_HEADER;
                n_lb       = '0;
                n_skip     = 1'b0;
            end
            default: ;
        endcase
    end

    // Query length clamped into the bin range.
    always_comb begin
        if (i_query_length == '0) begin
            w_qlen = LEN_W'(1);
        end else if (i_query_length > LEN_MAX) begin
            w_qlen = LEN_MAX;
        end else begin
            w_qlen = i_query_length;
        end
    end

    // Memory port selection.
    assign w_uaddr = ADDR_W'(r_upd_len - 1'b1);
    assign w_we    = i_cmd.clr_wr || i_cmd.upd_wr;
    assign w_waddr = i_cmd.clr_wr ? r_addr : w_uaddr;
    assign w_wdata = i_cmd.clr_wr ? '0 : sat_add(w_rdata, t_count'(1));
    assign w_raddr = i_cmd.upd_rd ? w_uaddr : r_addr;

    frlh_ram #(
        .P_WIDTH (COUNT_BITS),
        .P_DEPTH (P_MAX_LEN)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Divider operand and one restoring step.
    always_comb begin
        case (r_sel)
            2'd0:    w_cnt = r_ceq;
            2'd1:    w_cnt = r_cle;
            default: w_cnt = r_cge;
        endcase
        if (w_cnt > r_total) begin
            w_cnt = r_total;
        end
    end

    assign w_dsh   = PROD_W'(r_total) << r_k;
    assign w_quo_n = (r_rem >= w_dsh) ? (r_quo | (PCT_W'(1) << r_k)) : r_quo;
    assign w_plen  = LEN_W'(r_pidx) + 1'b1;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_lb      <= '0;
            r_skip    <= 1'b0;
            r_total   <= '0;
            r_longest <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan_issue;
            if (i_cmd.accept) begin
                r_phase <= n_phase;
                r_lb    <= n_lb;
                r_skip  <= n_skip;
            end
            if (i_cmd.clr_wr || i_cmd.scan_issue) begin
                r_addr <= (r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;
            end
            if (i_cmd.upd_wr) begin
                r_total <= sat_add(r_total, t_count'(1));
                if (r_upd_len > r_longest) begin
                    r_longest <= r_upd_len;
                end
            end
            if (i_cmd.load_out || i_cmd.load_now) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Request capture, scan sums and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_upd_len  <= r_lb;
            r_qlen     <= w_qlen;
            r_is_q     <= (i_action == ACT_QUERY);
            r_status_p <= w_status;
            r_ceq      <= '0;
            r_cle      <= '0;
            r_cge      <= '0;
            r_sel      <= 2'd0;
        end
        r_pidx <= r_addr;
        if (r_pend) begin
            if (w_plen == r_qlen) begin
                r_ceq <= w_rdata;
            end
            if (w_plen <= r_qlen) begin
                r_cle <= sat_add(r_cle, w_rdata);
            end
            if (w_plen >= r_qlen) begin
                r_cge <= sat_add(r_cge, w_rdata);
            end
        end
        if (i_cmd.mul) begin
            r_rem <= PROD_W'(w_cnt) * PROD_W'(PCT_SCALE);
            r_quo <= '0;
            r_k   <= K_W'(PCT_W - 1);
        end
        if (i_cmd.div_step) begin
            if (r_rem >= w_dsh) begin
                r_rem <= r_rem - w_dsh;
            end
            r_quo <= w_quo_n;
            r_k   <= r_k - 1'b1;
            if (r_k == '0) begin
                case (r_sel)
                    2'd0:    r_peq <= (r_total == '0) ? '0 : w_quo_n;
                    2'd1:    r_ple <= (r_total == '0) ? '0 : w_quo_n;
                    default: r_pge <= (r_total == '0) ? '0 : w_quo_n;
                endcase
                r_sel <= r_sel + 2'd1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now || i_cmd.load_out) begin
            r_o_status  <= i_cmd.load_now ? w_status : r_status_p;
            r_o_total   <= r_total;
            r_o_longest <= r_longest;
            if (i_cmd.load_out && r_is_q) begin
                r_o_row <= r_qlen;
                r_o_ceq <= r_ceq;
                r_o_cle <= r_cle;
                r_o_cge <= r_cge;
                r_o_peq <= r_peq;
                r_o_ple <= r_ple;
                r_o_pge <= r_pge;
            end else begin
                r_o_row <= '0;
                r_o_ceq <= '0;
                r_o_cle <= '0;
                r_o_cge <= '0;
                r_o_peq <= '0;
                r_o_ple <= '0;
                r_o_pge <= '0;
            end
        end
    end

    // Status toward the controller.
    assign o_stat.need_upd  = w_need_upd;
    assign o_stat.is_query  = (i_action == ACT_QUERY);
    assign o_stat.addr_last = (r_addr == ADDR_LAST);
    assign o_stat.div_last  = (r_k == '0);
    assign o_stat.sel_last  = (r_sel == 2'd2);
    assign o_stat.out_free  = !r_ov || i_out_ready;

    assign o_out_valid        = r_ov;
    assign o_status           = r_o_status;
    assign o_row_length       = r_o_row;
    assign o_count_equal      = r_o_ceq;
    assign o_count_at_most    = r_o_cle;
    assign o_count_at_least   = r_o_cge;
    assign o_percent_equal    = r_o_peq;
    assign o_percent_at_most  = r_o_ple;
    assign o_percent_at_least = r_o_pge;
    assign o_total_reads      = r_o_total;
    assign o_longest_length   = r_o_longest;

endmodule

### src/fastq_read_length_histogram_top.sv
// ----------------------------------------------------------------------------
// fastq_read_length_histogram_top
// FASTQ byte stream parser with a read length histogram and query rows.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bin memory to zero, one bin per cycle, and
// accepts no request meanwhile. A data byte, end of file or unused action that
// needs no bin update is accepted and loads the result register in the same
// cycle when the result register is free. A byte that ends a sequence line (or
// an end of file that closes one) goes through the accept, then the
// read-modify-write of its bin through the registered read of the bin memory,
// then the load of the result register. A query goes through the accept, one
// bin read per cycle to form the sums, a drain step for the last read, then
// one shared restoring divider that spends a scaling step and fifteen quotient
// bits on each of the three percentages, and finally the load of the result
// register. A stalled result register holds back the accept or the final load.
module fastq_read_length_histogram_top
    import frlh_pkg::*;
#(
    parameter int P_MAX_LEN = MAX_LEN,
    localparam int LEN_W = $clog2(P_MAX_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_data_byte,
    input  logic [LEN_W-1:0] i_query_length,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [LEN_W-1:0] o_row_length,
    output t_count           o_count_equal,
    output t_count           o_count_at_most,
    output t_count           o_count_at_least,
    output logic [PCT_W-1:0] o_percent_equal,
    output logic [PCT_W-1:0] o_percent_at_most,
    output logic [PCT_W-1:0] o_percent_at_least,
    output t_count           o_total_reads,
    output logic [LEN_W-1:0] o_longest_length
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    frlh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Parser, histogram and arithmetic.
    frlh_dp #(
        .P_MAX_LEN (P_MAX_LEN)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_action           (i_action),
        .i_data_byte        (i_data_byte),
        .i_query_length     (i_query_length),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_row_length       (o_row_length),
        .o_count_equal      (o_count_equal),
        .o_count_at_most    (o_count_at_most),
        .o_count_at_least   (o_count_at_least),
        .o_percent_equal    (o_percent_equal),
        .o_percent_at_most  (o_percent_at_most),
        .o_percent_at_least (o_percent_at_least),
        .o_total_reads      (o_total_reads),
        .o_longest_length   (o_longest_length)
    );

endmodule

### src/frlh_checker.sv
// ----------------------------------------------------------------------------
// frlh_checker
// Port-level checks of the read length histogram results.
// ----------------------------------------------------------------------------
module frlh_checker
    import frlh_pkg::*;
#(
    parameter int P_MAX_LEN = MAX_LEN,
    localparam int LEN_W = $clog2(P_MAX_LEN + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       o_status,
    input logic [LEN_W-1:0] o_row_length,
    input t_count           o_count_equal,
    input t_count           o_count_at_most,
    input t_count           o_count_at_least,
    input logic [PCT_W-1:0] o_percent_equal,
    input logic [PCT_W-1:0] o_percent_at_most,
    input logic [PCT_W-1:0] o_percent_at_least,
    input t_count           o_total_reads
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_reads)
            && $stable(o_count_at_most))
        else $error("result changed while stalled");

    // Percentages never exceed one hundred.
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_percent_equal <= PCT_W'(PCT_SCALE)
            && o_percent_at_most <= PCT_W'(PCT_SCALE)
            && o_percent_at_least <= PCT_W'(PCT_SCALE))
        else $error("percent above scale");

    // Rows that are not queries carry zero counts and a zero equal percentage.
    a_nonq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_length == '0 |-> o_count_equal == '0
            && o_count_at_most == '0 && o_count_at_least == '0
            && o_percent_equal == '0)
        else $error("statistics on a non-query result");

    // Errors only come from data bytes.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_row_length == '0)
        else $error("error status on a query row");

    // The single bin lies inside both cumulative sums.
    a_cum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_length != '0 |-> o_count_equal <= o_count_at_most
            && o_count_equal <= o_count_at_least)
        else $error("bin count above a cumulative sum");

endmodule

bind fastq_read_length_histogram_top frlh_checker #(.P_MAX_LEN(P_MAX_LEN)) u_chk (.*);

### tb/sv/tb_fastq_read_length_histogram_top.sv
// ----------------------------------------------------------------------------
// tb_fastq_read_length_histogram_top
// Self-checking bench for the FASTQ read length histogram. A short table of
// requests exercises errors, skipping, end of file and query clamping. It is
// followed by random FASTQ records, broken records, noise and queries. Every
// result is compared with an in-bench model of the parser and histogram.
// ----------------------------------------------------------------------------
module tb_fastq_read_length_histogram_top;
    import frlh_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         LEN_W      = 11;
    localparam int         N_RANDOM   = 1400;

    // One request of the stimulus stream, with an optional typed status.
    typedef struct {
        logic [1:0]       act;
        logic [7:0]       byte_val;
        logic [LEN_W-1:0] qlen;
        bit               typed;
        logic [1:0]       st;
    } t_req;

    // One statistics row as the block reports it.
    typedef struct {
        logic [1:0]       status;
        logic [LEN_W-1:0] row;
        t_count           c_eq, c_le, c_ge;
        logic [PCT_W-1:0] p_eq, p_le, p_ge;
        t_count           total;
        logic [LEN_W-1:0] longest;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_action = '0;
    logic [7:0]       i_data_byte = '0;
    logic [LEN_W-1:0] i_query_length = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic [LEN_W-1:0] o_row_length;
    t_count           o_count_equal, o_count_at_most, o_count_at_least;
    logic [PCT_W-1:0] o_percent_equal, o_percent_at_most, o_percent_at_least;
    t_count           o_total_reads;
    logic [LEN_W-1:0] o_longest_length;

    fastq_read_length_histogram_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the parser and histogram.
    t_count     hist_bins [MAX_LEN];
    t_count     hist_total;
    int         hist_longest;
    int         parse_phase;
    int         parse_bytes;
    bit         parse_skip;

    t_row       expected_rows[$];
    t_req       request_q[$];
    int         mismatches = 0;
    int         rows_checked = 0;
    int         queries_sent = 0;
    bit         quiet = 1'b0;
    bit         long_hold = 1'b0;

    // Close the current line; a sequence line goes into the histogram.
    task automatic close_line();
        int len;
        if (parse_bytes == 0) return;
        if (parse_phase == 1) begin
            len = (parse_bytes > MAX_LEN) ? MAX_LEN : parse_bytes;
            if (hist_bins[len-1] != '1) hist_bins[len-1]++;
            if (hist_total != '1) hist_total++;
            if (len > hist_longest) hist_longest = len;
        end
        parse_phase = (parse_phase + 1) % 4;
        parse_bytes = 0;
    endtask

    function automatic logic [PCT_W-1:0] percent_of(longint unsigned c);
        if (hist_total == 0) return '0;
        if (c > hist_total) c = hist_total;
        return PCT_W'((c * PCT_SCALE) / hist_total);
    endfunction

    // Advance the model by one request and form the row it gives.
    task automatic histogram_step(input t_req r, output t_row res);
        int q;
        longint unsigned le, ge;
        res = '{default: '0};
        case (r.act)
            ACT_DATA: begin
                if (parse_skip) begin
                    res.status = ST_SKIPPED;
                end else if (r.byte_val == CH_NEWLINE) begin
                    close_line();
                end else if (parse_bytes == 0 && parse_phase == 0 && r.byte_val != CH_AT) begin
                    res.status = ST_BAD_HDR;
                    parse_skip = 1'b1;
                end else if (parse_bytes == 0 && parse_phase == 2 &&
                             r.byte_val != CH_PLUS) begin
                    res.status = ST_BAD_SEP;
                    parse_skip = 1'b1;
                end else if (parse_bytes < MAX_LEN) begin
                    parse_bytes++;
                end
            end
            ACT_EOF: begin
                if (!parse_skip) close_line();
                parse_phase = 0;
                parse_bytes = 0;
                parse_skip = 1'b0;
            end
            ACT_QUERY: begin
                q = r.qlen;
                if (q < 1) q = 1;
                if (q > MAX_LEN) q = MAX_LEN;
                le = 0;
                ge = 0;
                for (int i = 0; i < MAX_LEN; i++) begin
                    if (i < q) le += hist_bins[i];
                    if (i + 1 >= q) ge += hist_bins[i];
                end
                if (le > 64'hFFFF_FFFF) le = 64'hFFFF_FFFF;
                if (ge > 64'hFFFF_FFFF) ge = 64'hFFFF_FFFF;
                res.row = LEN_W'(q);
                res.c_eq = hist_bins[q-1];
                res.c_le = t_count'(le);
                res.c_ge = t_count'(ge);
                res.p_eq = percent_of(hist_bins[q-1]);
                res.p_le = percent_of(le);
                res.p_ge = percent_of(ge);
            end
            default: ;
        endcase
        res.total = hist_total;
        res.longest = LEN_W'(hist_longest);
    endtask

    task automatic add_req(input logic [1:0] act, input logic [7:0] b,
                           input logic [LEN_W-1:0] q);
        request_q.insert(request_q.size(), '{act, b, q, 1'b0, ST_OK});
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == CH_NEWLINE) ? 8'h0B : b;
    endfunction

    task automatic add_line(input logic [7:0] first, input int len);
        add_req(ACT_DATA, first, '0);
        for (int i = 1; i < len; i++) add_req(ACT_DATA, text_byte(), '0);
        add_req(ACT_DATA, CH_NEWLINE, '0);
    endtask

    // Random part: mostly well-formed records, with broken ones and noise.
    task automatic build_random();
        int kind, len, long_reads;
        long_reads = 0;
        while (request_q.size() < N_RANDOM) begin
            kind = $urandom_range(0, 99);
            if (kind < 68) begin
                add_line(CH_AT, $urandom_range(1, 6));
                if ($urandom_range(0, 9) == 0) add_req(ACT_DATA, CH_NEWLINE, '0);
                if (long_reads < 2 && $urandom_range(0, 40) == 0) begin
                    len = $urandom_range(1000, 1060);
                    long_reads++;
                end else begin
                    len = $urandom_range(1, 30);
                end
                add_line(text_byte(), len);
                if ($urandom_range(0, 7) == 0) begin
                    // Record cut short by the end of its file.
                    add_req(ACT_EOF, 8'($urandom), 11'($urandom));
                    continue;
                end
                add_line(CH_PLUS, $urandom_range(1, 4));
                add_line(text_byte(), $urandom_range(1, 8));
            end else if (kind < 78) begin
                add_line(text_byte(), $urandom_range(1, 5));
                add_line(text_byte(), $urandom_range(1, 5));
                add_req(ACT_EOF, '0, '0);
            end else if (kind < 86) begin
                add_req(ACT_QUERY, 8'($urandom),
                        $urandom_range(0, 1) ? 11'($urandom_range(0, 40)) : 11'($urandom));
            end else if (kind < 92) begin
                add_req(ACT_EOF, 8'($urandom), 11'($urandom));
            end else if (kind < 96) begin
                add_req(ACT_UNUSED, 8'($urandom), 11'($urandom));
            end else begin
                add_req(ACT_DATA, 8'($urandom), 11'($urandom));
            end
        end
    endtask

    // Offer one request and wait for its acceptance.
    task automatic send_req(input t_req r);
        t_row res;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_action = r.act;
        i_data_byte = r.byte_val;
        i_query_length = r.qlen;
        do @(posedge i_clk); while (!o_in_ready);
        histogram_step(r, res);
        if (r.typed) res.status = r.st;
        if (r.act == ACT_QUERY) queries_sent++;
        expected_rows.insert(expected_rows.size(), res);
    endtask

    // Request sender.
    initial begin
        t_req directed[] = '{
            '{ACT_QUERY,  8'h00,      11'd0,    1'b1, ST_OK},
            '{ACT_QUERY,  8'hFF,      11'd2047, 1'b1, ST_OK},
            '{ACT_DATA,   8'h41,      11'd0,    1'b1, ST_BAD_HDR},
            '{ACT_DATA,   CH_NEWLINE, 11'd0,    1'b1, ST_SKIPPED},
            '{ACT_EOF,    8'h00,      11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   CH_AT,      11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   CH_NEWLINE, 11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   8'h43,      11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   8'h47,      11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   CH_NEWLINE, 11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   8'h78,      11'd0,    1'b1, ST_BAD_SEP},
            '{ACT_DATA,   8'h79,      11'd0,    1'b1, ST_SKIPPED},
            '{ACT_EOF,    8'h00,      11'd0,    1'b1, ST_OK},
            '{ACT_DATA,   CH_AT,      11'd0,    1'b0, ST_OK},
            '{ACT_DATA,   CH_NEWLINE, 11'd0,    1'b0, ST_OK},
            '{ACT_DATA,   8'h41,      11'd0,    1'b0, ST_OK},
            '{ACT_EOF,    8'h00,      11'd0,    1'b0, ST_OK},
            '{ACT_DATA,   8'hFF,      11'd0,    1'b1, ST_BAD_HDR},
            '{ACT_EOF,    8'h00,      11'd0,    1'b1, ST_OK},
            '{ACT_UNUSED, 8'hFF,      11'd2047, 1'b1, ST_OK},
            '{ACT_DATA,   CH_NEWLINE, 11'd0,    1'b1, ST_OK},
            '{ACT_QUERY,  8'h00,      11'd1,    1'b0, ST_OK},
            '{ACT_QUERY,  8'h00,      11'd2,    1'b0, ST_OK},
            '{ACT_QUERY,  8'h00,      11'd1024, 1'b0, ST_OK},
            '{ACT_DATA,   8'h00,      11'd0,    1'b1, ST_BAD_HDR}
        };
        int n;
        hist_bins = '{default: '0};
        hist_total = '0;
        hist_longest = 0;
        parse_phase = 0;
        parse_bytes = 0;
        parse_skip = 1'b0;
        build_random();

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_req(directed[i]);

        n = request_q.size();
        foreach (request_q[i]) begin
            if (i == 300) long_hold = 1'b1;
            if (i == 700) begin
                // Let the block drain fully before going on.
                @(negedge i_clk);
                i_in_valid = 1'b0;
                wait (expected_rows.size() == 0);
            end
            if (i == n - 150) quiet = 1'b1;
            send_req(request_q[i]);
            if (!quiet && !long_hold && $urandom_range(0, 5) == 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        wait (expected_rows.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d result rows, %0d of them query rows, %0d reads counted.",
                 rows_checked, queries_sent, hist_total);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result receiver with random stalls and one long hold-off.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                stall_left = 400;
                long_hold = 1'b0;
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Compare every accepted result with the oldest expected row.
    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending, status %0d",
                         $time, o_status);
            end else begin
                e = expected_rows.pop_front();
                rows_checked++;
                check_field("status", e.status, o_status);
                check_field("row_length", e.row, o_row_length);
                check_field("count_equal", e.c_eq, o_count_equal);
                check_field("count_at_most", e.c_le, o_count_at_most);
                check_field("count_at_least", e.c_ge, o_count_at_least);
                check_field("percent_equal", e.p_eq, o_percent_equal);
                check_field("percent_at_most", e.p_le, o_percent_at_most);
                check_field("percent_at_least", e.p_ge, o_percent_at_least);
                check_field("total_reads", e.total, o_total_reads);
                check_field("longest_length", e.longest, o_longest_length);
            end
        end
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", expected_rows.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

### fastq_read_length_histogram_top.f
src/frlh_pkg.sv
src/frlh_ram.sv
src/frlh_ctrl.sv
src/frlh_dp.sv
src/fastq_read_length_histogram_top.sv
src/frlh_checker.sv
tb/sv/tb_fastq_read_length_histogram_top.sv
